### rtl/mnv_pkg.sv
`default_nettype none

package mnv_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned LenW   = 32;
  localparam int unsigned PitchW = 7;
  localparam int unsigned ProbW  = 17;
  localparam int unsigned BoundW = 19;
  localparam int unsigned GridW  = 22;
  localparam int unsigned MaskW  = 12;
  localparam int unsigned NumVar = 6;

  localparam logic [MaskW-1:0] ScaleMaskReset = 12'd2741;
  localparam logic [GridW-1:0] GridStepReset  = 22'd16384;

  // Register map, word index on the APB port
  typedef enum logic [2:0] {
    REG_SCALE_MASK    = 3'd0,
    REG_GRID_STEP     = 3'd1,
    REG_PROB_REST     = 3'd2,
    REG_PROB_LEAP     = 3'd3,
    REG_PROB_PUSH     = 3'd4,
    REG_PROB_DOUBLE   = 3'd5,
    REG_PROB_APPROACH = 3'd6,
    REG_PROB_ORNAMENT = 3'd7
  } cfg_reg_e;

  // Variation chosen for one word; order of the first six follows the roll bounds
  typedef enum logic [2:0] {
    VAR_REST     = 3'd0,
    VAR_LEAP     = 3'd1,
    VAR_PUSH     = 3'd2,
    VAR_DOUBLE   = 3'd3,
    VAR_APPROACH = 3'd4,
    VAR_ORNAMENT = 3'd5,
    VAR_PLAIN    = 3'd6,
    VAR_ECHO     = 3'd7
  } var_e;

  typedef struct packed {
    logic              kind;
    logic [PitchW-1:0] pitch;
    logic [PitchW-1:0] velocity;
    logic [TimeW-1:0]  start_time;
    logic [LenW-1:0]   length;
    logic [15:0]       roll;
    logic              up_draw;
  } item_t;

  typedef struct packed {
    logic              pass_through;
    logic [PitchW-1:0] pitch;
    logic [PitchW-1:0] velocity;
    logic [TimeW-1:0]  time_v;
    logic [LenW-1:0]   length;
    logic              last_of_run;
  } res_t;

  typedef struct packed {
    logic [MaskW-1:0]                scale_mask;
    logic [GridW-1:0]                grid_step;
    logic [NumVar-1:0][BoundW-1:0]   bound;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [PitchW-1:0] pitch;
  } pitch_upd_t;

  // Saturating add of a length onto a time stamp
  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] t, logic [LenW-1:0] a);
    logic [TimeW:0] s;
    s = {1'b0, t} + {{(TimeW+1-LenW){1'b0}}, a};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  // Pitch class: octave from p*43/512, exact for p up to 127
  function automatic logic [3:0] pitch_class(logic [PitchW-1:0] p);
    logic [12:0] m;
    logic [6:0]  o12;
    m   = {6'b0, p} * 13'd43;
    o12 = {3'b0, m[12:9]} * 7'd12;
    return 4'(p - o12);
  endfunction

  // Nearest pitch strictly above or below whose class is in the mask
  function automatic logic [PitchW-1:0] scale_neighbour(logic [PitchW-1:0] p, logic above,
                                                         logic [MaskW-1:0] mask);
    logic [3:0] pc;
    logic [4:0] cls;
    logic [7:0] cand;
    logic       found;
    logic [6:0] best;
    pc    = pitch_class(p);
    found = 1'b0;
    best  = '0;
    // scan offsets from far to near so the nearest one wins
    for (int d = 12; d >= 1; d--) begin
      if (above) cls = {1'b0, pc} + 5'(d);
      else       cls = {1'b0, pc} + 5'(12 - d);
      if (cls >= 5'd12) cls = cls - 5'd12;
      if (above) cand = {1'b0, p} + 8'(d);
      else       cand = {1'b0, p} - 8'(d);
      if (mask[cls[3:0]] && !cand[7]) begin
        found = 1'b1;
        best  = cand[6:0];
      end
    end
    // no scale tone in range: step by one, held at the edges
    if (!found) begin
      if (above) best = (p == 7'd127) ? 7'd127 : p + 7'd1;
      else       best = (p == 7'd0)   ? 7'd0   : p - 7'd1;
    end
    return best;
  endfunction

  // floor((17v+10)/20) via reciprocal 3277/65536, held at least 1
  function automatic logic [PitchW-1:0] approach_vel(logic [PitchW-1:0] v);
    logic [11:0] x;
    logic [23:0] prod;
    logic [6:0]  av;
    x    = {5'b0, v} * 12'd17 + 12'd10;
    prod = {12'b0, x} * 24'd3277;
    av   = prod[22:16];
    return (av == 7'd0) ? 7'd1 : av;
  endfunction

endpackage

`default_nettype wire

### rtl/mnv_cfg.sv
`default_nettype none

module mnv_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output mnv_pkg::cfg_t      cfg_o
);
  import mnv_pkg::*;

  logic [MaskW-1:0]  scale_mask_q;
  logic [GridW-1:0]  grid_step_q;
  logic [ProbW-1:0]  prob_q [NumVar];
  logic [NumVar-1:0][BoundW-1:0] bound_q, bound_d;
  logic              wr_en;
  cfg_reg_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cfg_reg_e'(paddr[4:2]);

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mask_q <= ScaleMaskReset;
      grid_step_q  <= GridStepReset;
      for (int i = 0; i < NumVar; i++) prob_q[i] <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SCALE_MASK:    scale_mask_q <= pwdata[MaskW-1:0];
        REG_GRID_STEP:     grid_step_q  <= pwdata[GridW-1:0];
        REG_PROB_REST:     prob_q[0]    <= pwdata[ProbW-1:0];
        REG_PROB_LEAP:     prob_q[1]    <= pwdata[ProbW-1:0];
        REG_PROB_PUSH:     prob_q[2]    <= pwdata[ProbW-1:0];
        REG_PROB_DOUBLE:   prob_q[3]    <= pwdata[ProbW-1:0];
        REG_PROB_APPROACH: prob_q[4]    <= pwdata[ProbW-1:0];
        REG_PROB_ORNAMENT: prob_q[5]    <= pwdata[ProbW-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_SCALE_MASK:    prdata = {20'b0, scale_mask_q};
      REG_GRID_STEP:     prdata = {10'b0, grid_step_q};
      REG_PROB_REST:     prdata = {15'b0, prob_q[0]};
      REG_PROB_LEAP:     prdata = {15'b0, prob_q[1]};
      REG_PROB_PUSH:     prdata = {15'b0, prob_q[2]};
      REG_PROB_DOUBLE:   prdata = {15'b0, prob_q[3]};
      REG_PROB_APPROACH: prdata = {15'b0, prob_q[4]};
      REG_PROB_ORNAMENT: prdata = {15'b0, prob_q[5]};
    endcase
  end

  // Running sums of the probabilities, 19 bits wide; a total past 2^19-1 wraps
  always_comb begin
    logic [BoundW-1:0] acc;
    acc = '0;
    for (int i = 0; i < NumVar; i++) begin
      acc        = acc + {{(BoundW-ProbW){1'b0}}, prob_q[i]};
      bound_d[i] = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bound_q <= '0;
    else         bound_q <= bound_d;
  end

  assign cfg_o.scale_mask = scale_mask_q;
  assign cfg_o.grid_step  = grid_step_q;
  assign cfg_o.bound      = bound_q;

endmodule

`default_nettype wire

### rtl/mnv_vary.sv
`default_nettype none

module mnv_vary (
  input  mnv_pkg::item_t           item_i,
  input  mnv_pkg::cfg_t            cfg_i,
  input  wire logic [6:0]          last_pitch_i,
  input  wire logic                have_last_i,
  output mnv_pkg::res_t [2:0]      res_o,
  output logic [1:0]               count_o,
  output mnv_pkg::pitch_upd_t      upd_o
);
  import mnv_pkg::*;

  var_e              sel;
  logic [PitchW-1:0] p;
  logic [PitchW-1:0] v;
  logic [TimeW-1:0]  t;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   half, quarter, cap, lead, addend;
  logic [7:0]        hi;
  logic [PitchW-1:0] lo, leap_p, nb, av;
  logic              from_below, nb_above;
  logic [TimeW-1:0]  t_sum, t_push, t_2q;

  assign p   = item_i.pitch;
  assign v   = item_i.velocity;
  assign t   = item_i.start_time;
  assign len = item_i.length;

  // Pick the first bound the roll falls below
  always_comb begin
    sel = VAR_PLAIN;
    for (int i = NumVar - 1; i >= 0; i--) begin
      if ({3'b0, item_i.roll} < cfg_i.bound[i]) sel = var_e'(3'(i));
    end
    if (item_i.kind || (len == '0)) sel = VAR_ECHO;
  end

  // Octave leap folded at the range edges
  assign hi     = {1'b0, p} + 8'd12;
  assign lo     = p - 7'd12;
  assign leap_p = item_i.up_draw ? (hi[7] ? lo : hi[6:0])
                                 : ((p >= 7'd12) ? lo : hi[6:0]);

  // Split lengths
  assign half    = len >> 1;
  assign quarter = len >> 2;
  assign cap     = {{(LenW-GridW+1){1'b0}}, cfg_i.grid_step[GridW-1:1]};
  assign lead    = (quarter > cap) ? cap : quarter;

  // Neighbour direction
  assign from_below = (have_last_i && (last_pitch_i != p)) ? (last_pitch_i < p)
                                                           : item_i.up_draw;
  assign nb_above   = (sel == VAR_APPROACH) ? !from_below : item_i.up_draw;
  assign nb         = scale_neighbour(p, nb_above, cfg_i.scale_mask);
  assign av         = approach_vel(v);

  // Time of the second part, or the moved time of a pushed note
  always_comb begin
    case (sel)
      VAR_DOUBLE:   addend = half;
      VAR_APPROACH: addend = lead;
      VAR_ORNAMENT: addend = quarter;
      default:      addend = {{(LenW-GridW){1'b0}}, cfg_i.grid_step};
    endcase
  end

  assign t_sum  = sat_add(t, addend);
  assign t_push = (item_i.up_draw || (t < {{(TimeW-GridW){1'b0}}, cfg_i.grid_step}))
                  ? t_sum : t - {{(TimeW-GridW){1'b0}}, cfg_i.grid_step};
  assign t_2q   = sat_add(t, {quarter[LenW-2:0], 1'b0});

  // Assemble the result words
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_o[k].pass_through = 1'b0;
      res_o[k].pitch        = p;
      res_o[k].velocity     = v;
      res_o[k].time_v       = t;
      res_o[k].length       = len;
      res_o[k].last_of_run  = 1'b0;
    end
    count_o   = 2'd1;
    upd_o.en  = 1'b1;
    upd_o.pitch = p;
    unique case (sel)
      VAR_ECHO: begin
        res_o[0].pass_through = 1'b1;
        res_o[0].last_of_run  = 1'b1;
        upd_o.en              = 1'b0;
      end
      VAR_PLAIN: begin
        res_o[0].pass_through = 1'b1;
        res_o[0].last_of_run  = 1'b1;
      end
      VAR_REST: begin
        count_o  = 2'd0;
        upd_o.en = 1'b0;
      end
      VAR_LEAP: begin
        res_o[0].pitch       = leap_p;
        res_o[0].last_of_run = 1'b1;
        upd_o.pitch          = leap_p;
      end
      VAR_PUSH: begin
        res_o[0].time_v      = t_push;
        res_o[0].last_of_run = 1'b1;
      end
      VAR_DOUBLE: begin
        count_o              = 2'd2;
        res_o[0].length      = half;
        res_o[1].time_v      = t_sum;
        res_o[1].length      = len - half;
        res_o[1].last_of_run = 1'b1;
      end
      VAR_APPROACH: begin
        count_o              = 2'd2;
        res_o[0].pitch       = nb;
        res_o[0].velocity    = av;
        res_o[0].length      = lead;
        res_o[1].time_v      = t_sum;
        res_o[1].length      = len - lead;
        res_o[1].last_of_run = 1'b1;
      end
      VAR_ORNAMENT: begin
        count_o              = 2'd3;
        res_o[0].length      = quarter;
        res_o[1].pitch       = nb;
        res_o[1].time_v      = t_sum;
        res_o[1].length      = quarter;
        res_o[2].time_v      = t_2q;
        res_o[2].length      = len - {quarter[LenW-2:0], 1'b0};
        res_o[2].last_of_run = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mnv_outq.sv
`default_nettype none

module mnv_outq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  mnv_pkg::res_t [2:0] res_i,
  input  wire logic [1:0]     count_i,
  input  wire logic           ready_i,
  output logic                valid_o,
  output mnv_pkg::res_t       head_o,
  output logic                space_o
);
  import mnv_pkg::*;

  res_t [2:0] buf_q, buf_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign space_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign head_o  = buf_q[0];

  // Load a fresh set of words or shift out the head
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = res_i;
      cnt_d = count_i;
    end else if (pop) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

### rtl/melodic_note_variation_core.sv
`default_nettype none

// Channel    Dir  Handshake              tdata / tuser / tlast
// s_axis     in   tvalid/tready          note event, variation roll
// m_axis     out  tvalid/tready          one emitted note event, pass flag, end of run
// apb        in   psel/penable/pready    eight config registers at 4*i
//
// An event is registered in the input register, worked out combinationally and its
// 0 to 3 words are loaded into a three-entry output buffer once the buffer has space;
// the words then leave from the buffer head on m_axis.
// The single output port drains the buffer while the input register holds the next event,
// whose words load as the last buffered word leaves or into an empty buffer; a rest loads none.
// Reset loads register defaults and clears pitch history; no clearing pass.
// An output stall holds the buffer, then the input register, then s_axis_tready.
module melodic_note_variation_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pitch, velocity, start_time, length, roll, up_draw, zero pad
  input  wire logic [111:0] s_axis_tdata,
  // kind
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_pitch, out_velocity, out_time, out_length, zero pad
  output logic [95:0]       m_axis_tdata,
  // pass_through
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mnv_pkg::*;

  cfg_t         cfg;
  item_t        in_q, in_d;
  logic         in_valid_q, in_valid_d;
  logic         s_fire, load, space;
  res_t [2:0]   res;
  logic [1:0]   count;
  pitch_upd_t   upd;
  res_t         head;
  logic [6:0]   last_pitch_q;
  logic         have_last_q;

  mnv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register
  assign load          = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || load;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_d.kind       = s_axis_tuser;
  assign in_d.pitch      = s_axis_tdata[6:0];
  assign in_d.velocity   = s_axis_tdata[13:7];
  assign in_d.start_time = s_axis_tdata[61:14];
  assign in_d.length     = s_axis_tdata[93:62];
  assign in_d.roll       = s_axis_tdata[109:94];
  assign in_d.up_draw    = s_axis_tdata[110];

  assign in_valid_d = s_fire ? 1'b1 : (load ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else         in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) in_q <= in_d;
  end

  mnv_vary u_vary (
    .item_i       (in_q),
    .cfg_i        (cfg),
    .last_pitch_i (last_pitch_q),
    .have_last_i  (have_last_q),
    .res_o        (res),
    .count_o      (count),
    .upd_o        (upd)
  );

  // Track the last pitch sent out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pitch_q <= '0;
      have_last_q  <= 1'b0;
    end else if (load && upd.en) begin
      last_pitch_q <= upd.pitch;
      have_last_q  <= 1'b1;
    end
  end

  mnv_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (res),
    .count_i (count),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .space_o (space)
  );

  assign m_axis_tdata = {2'b00, head.length, head.time_v, head.velocity, head.pitch};
  assign m_axis_tuser = head.pass_through;
  assign m_axis_tlast = head.last_of_run;

endmodule

`default_nettype wire

### rtl/mnv_checker.sv
`default_nettype none

module mnv_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [95:0]  m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // An echoed word is always the only word of its run
  a_pass_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("pass-through word without tlast");

  // Input backs up only behind a pending output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

endmodule

bind melodic_note_variation_core mnv_checker u_mnv_checker (.*);

`default_nettype wire

### bench/tb_melodic_note_variation_core.sv
module tb_melodic_note_variation_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mnv_pkg::*;

  localparam logic [47:0] TimeTop = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] LenTop  = 32'hFFFF_FFFF;

  // Expected output words, worked out from each accepted note event
  class variation_scoreboard;
    logic [11:0] scale_mask;
    logic [21:0] grid;
    logic [16:0] prob [6];
    logic [6:0]  last_pitch;
    bit          have_last;
    res_t        expected_words [$];
    int          errors;

    function new();
      scale_mask = ScaleMaskReset;
      grid       = GridStepReset;
      foreach (prob[i]) prob[i] = '0;
      last_pitch = '0;
      have_last  = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [31:0] v);
      case (r)
        REG_SCALE_MASK: scale_mask = v[11:0];
        REG_GRID_STEP:  grid = v[21:0];
        default:        prob[int'(r) - int'(REG_PROB_REST)] = v[16:0];
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [47:0] time_plus(logic [47:0] t, logic [47:0] d);
      logic [48:0] s;
      s = {1'b0, t} + {1'b0, d};
      return s[48] ? TimeTop : s[47:0];
    endfunction

    // Nearest pitch in the scale strictly above or below, else one step, held at the edges
    function logic [6:0] scale_step(logic [6:0] p, bit above);
      int best;
      int pi;
      best = -1;
      pi   = int'(p);
      for (int c = 0; c < 128; c++) begin
        if (scale_mask[c % 12]) begin
          if (above && c > pi && best < 0) best = c;
          if (!above && c < pi) best = c;
        end
      end
      if (best < 0) best = above ? pi + 1 : pi - 1;
      if (best < 0) best = 0;
      if (best > 127) best = 127;
      return 7'(best);
    endfunction

    function void emit(bit pass, logic [6:0] p, logic [6:0] v, logic [47:0] t,
                       logic [31:0] len, bit last);
      res_t w;
      w = {pass, p, v, t, len, last};
      expected_words.push_back(w);
    endfunction

    function void accept_event(item_t e);
      var_e        choice;
      logic [19:0] bound;
      logic [6:0]  np;
      logic [47:0] nt;
      logic [31:0] h;
      logic [31:0] lead;
      logic [31:0] q;
      int          av;
      bit          from_below;
      // echo other events and held notes, state untouched
      if (e.kind || e.length == '0) begin
        emit(1'b1, e.pitch, e.velocity, e.start_time, e.length, 1'b1);
        return;
      end
      // walk the running sums in fixed order
      choice = VAR_PLAIN;
      bound  = '0;
      for (int i = 0; i < NumVar; i++) begin
        bound = bound + 20'(prob[i]);
        if (choice == VAR_PLAIN && 20'(e.roll) < bound) choice = var_e'(i);
      end
      case (choice)
        VAR_REST: ;
        VAR_LEAP: begin
          if (e.up_draw) np = (e.pitch <= 7'd115) ? e.pitch + 7'd12 : e.pitch - 7'd12;
          else           np = (e.pitch >= 7'd12) ? e.pitch - 7'd12 : e.pitch + 7'd12;
          last_pitch = np;
          emit(1'b0, np, e.velocity, e.start_time, e.length, 1'b1);
        end
        VAR_PUSH: begin
          if (e.up_draw || e.start_time < 48'(grid)) nt = time_plus(e.start_time, 48'(grid));
          else nt = e.start_time - 48'(grid);
          emit(1'b0, e.pitch, e.velocity, nt, e.length, 1'b1);
        end
        VAR_DOUBLE: begin
          h = e.length >> 1;
          emit(1'b0, e.pitch, e.velocity, e.start_time, h, 1'b0);
          emit(1'b0, e.pitch, e.velocity, time_plus(e.start_time, 48'(h)), e.length - h, 1'b1);
        end
        VAR_APPROACH: begin
          from_below = (have_last && last_pitch != e.pitch) ? (last_pitch < e.pitch)
                                                            : e.up_draw;
          lead = e.length >> 2;
          if (lead > 32'(grid >> 1)) lead = 32'(grid >> 1);
          av = (17 * int'(e.velocity) + 10) / 20;
          if (av < 1) av = 1;
          if (av > 127) av = 127;
          emit(1'b0, scale_step(e.pitch, !from_below), 7'(av), e.start_time, lead, 1'b0);
          emit(1'b0, e.pitch, e.velocity, time_plus(e.start_time, 48'(lead)),
               e.length - lead, 1'b1);
        end
        VAR_ORNAMENT: begin
          q = e.length >> 2;
          emit(1'b0, e.pitch, e.velocity, e.start_time, q, 1'b0);
          emit(1'b0, scale_step(e.pitch, e.up_draw), e.velocity,
               time_plus(e.start_time, 48'(q)), q, 1'b0);
          emit(1'b0, e.pitch, e.velocity, time_plus(e.start_time, 48'({q, 1'b0})),
               e.length - {q[30:0], 1'b0}, 1'b1);
        end
        default: emit(1'b1, e.pitch, e.velocity, e.start_time, e.length, 1'b1);
      endcase
      // every played note updates the pitch history
      if (choice != VAR_REST) begin
        have_last = 1'b1;
        if (choice != VAR_LEAP) last_pitch = e.pitch;
      end
    endfunction

    function void flag(string what, res_t want, res_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s: expected pass=%0d pitch=%0d vel=%0d time=%h len=%h last=%0d", what,
                 want.pass_through, want.pitch, want.velocity, want.time_v, want.length,
                 want.last_of_run);
        $display("%s: actual   pass=%0d pitch=%0d vel=%0d time=%h len=%h last=%0d", what,
                 got.pass_through, got.pitch, got.velocity, got.time_v, got.length,
                 got.last_of_run);
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_words.size() == 0) begin
        flag("unexpected word", '0, got);
        return;
      end
      want = expected_words.pop_front();
      if (got.pass_through !== want.pass_through || got.pitch !== want.pitch ||
          got.velocity !== want.velocity || got.time_v !== want.time_v ||
          got.length !== want.length || got.last_of_run !== want.last_of_run)
        flag("word mismatch", want, got);
    endfunction
  endclass

  logic          clk_i         = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata  = '0;
  logic          s_axis_tuser  = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [95:0]   m_axis_tdata;
  logic          m_axis_tuser;
  logic          m_axis_tlast;
  logic          psel          = 1'b0;
  logic          penable       = 1'b0;
  logic          pwrite        = 1'b0;
  logic [4:0]    paddr         = '0;
  logic [31:0]   pwdata        = '0;
  logic [31:0]   prdata;
  logic          pready;

  bit            calm_phase    = 1'b0;
  variation_scoreboard sb      = new();

  melodic_note_variation_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t mk_note(logic kind, logic [6:0] p, logic [6:0] v, logic [47:0] t,
                                    logic [31:0] len, logic [15:0] roll, logic up);
    item_t e;
    e.kind       = kind;
    e.pitch      = p;
    e.velocity   = v;
    e.start_time = t;
    e.length     = len;
    e.roll       = roll;
    e.up_draw    = up;
    return e;
  endfunction

  function automatic item_t random_event();
    item_t e;
    int    sel;
    e.kind = ($urandom_range(0, 9) == 0);
    sel = $urandom_range(0, 9);
    if (sel == 0)      e.pitch = 7'($urandom_range(0, 11));
    else if (sel == 1) e.pitch = 7'($urandom_range(116, 127));
    else               e.pitch = 7'($urandom_range(0, 127));
    e.velocity = 7'($urandom_range(0, 127));
    sel = $urandom_range(0, 9);
    if (sel == 0)      e.start_time = TimeTop - 48'($urandom_range(0, 1 << 22));
    else if (sel == 1) e.start_time = 48'($urandom_range(0, 1 << 22));
    else               e.start_time = 48'({$urandom, $urandom});
    sel = $urandom_range(0, 11);
    if (sel == 0)      e.length = '0;
    else if (sel == 1) e.length = $urandom;
    else if (sel == 2) e.length = LenTop - 32'($urandom_range(0, 1 << 12));
    else               e.length = 32'($urandom_range(1, 1 << 20));
    e.roll    = 16'($urandom);
    e.up_draw = 1'($urandom_range(0, 1));
    return e;
  endfunction

  // Setup then access cycle; the register takes the value on the access edge
  task automatic apb_write(cfg_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic load_profile(logic [11:0] mask, logic [21:0] grid, logic [5:0][16:0] pr);
    apb_write(REG_SCALE_MASK, 32'(mask));
    apb_write(REG_GRID_STEP, 32'(grid));
    for (int i = 0; i < NumVar; i++)
      apb_write(cfg_reg_e'(int'(REG_PROB_REST) + i), 32'(pr[i]));
  endtask

  // Offer one event word after an optional gap, hold until accepted
  task automatic push_event(item_t e);
    int gap;
    gap = calm_phase ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= e.kind;
    s_axis_tdata  <= {1'b0, e.up_draw, e.roll, e.length, e.start_time, e.velocity, e.pitch};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_event(e);
  endtask

  // Drop valid, wait for every expected word, then let a rest clear the pipe
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Output side: random stalls between runs of ready
  initial begin : out_ready
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      n = calm_phase ? 0 : gap_len();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each output word on the handshake edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word({m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[13:7],
                     m_axis_tdata[61:14], m_axis_tdata[93:62], m_axis_tlast});
  end

  initial begin : stimulus
    logic [5:0][16:0] pr;
    logic [11:0]      mask;
    logic [21:0]      grid;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Echo of a non-note and of a held note under reset settings
    push_event(mk_note(1'b1, 7'd127, 7'd127, TimeTop, LenTop, 16'hFFFF, 1'b1));
    push_event(mk_note(1'b0, 7'd0, 7'd0, 48'd0, 32'd0, 16'd0, 1'b0));
    drain();

    // Approach with empty scale, first one before any pitch history
    pr    = '0;
    pr[4] = 17'd65536;
    load_profile(12'd0, 22'd3932160, pr);
    push_event(mk_note(1'b0, 7'd64, 7'd0, 48'd0, 32'd100, 16'd0, 1'b1));
    push_event(mk_note(1'b0, 7'd64, 7'd127, 48'd5000, 32'd100, 16'd1234, 1'b0));
    push_event(mk_note(1'b0, 7'd0, 7'd127, TimeTop - 48'd5, LenTop, 16'hFFFF, 1'b1));
    push_event(mk_note(1'b0, 7'd127, 7'd1, 48'd77, 32'd9, 16'd0, 1'b0));
    drain();

    // Octave leap folded at both edges
    pr    = '0;
    pr[1] = 17'd65536;
    load_profile(ScaleMaskReset, GridStepReset, pr);
    push_event(mk_note(1'b0, 7'd127, 7'd90, 48'd10, 32'd500, 16'd0, 1'b1));
    push_event(mk_note(1'b0, 7'd0, 7'd90, 48'd10, 32'd500, 16'd0, 1'b0));
    push_event(mk_note(1'b0, 7'd60, 7'd90, 48'd10, 32'd500, 16'd0, 1'b1));
    push_event(mk_note(1'b0, 7'd60, 7'd90, 48'd10, 32'd500, 16'd0, 1'b0));
    drain();

    // Push: forced late near zero, saturating, early
    pr    = '0;
    pr[2] = 17'd65536;
    load_profile(ScaleMaskReset, 22'd655, pr);
    push_event(mk_note(1'b0, 7'd50, 7'd60, 48'd10, 32'd700, 16'd0, 1'b0));
    push_event(mk_note(1'b0, 7'd50, 7'd60, TimeTop, 32'd700, 16'd0, 1'b1));
    push_event(mk_note(1'b0, 7'd50, 7'd60, 48'd100000, 32'd700, 16'd0, 1'b0));
    drain();

    // Double: odd minimum length and full length with saturated time
    pr    = '0;
    pr[3] = 17'd65536;
    load_profile(ScaleMaskReset, GridStepReset, pr);
    push_event(mk_note(1'b0, 7'd64, 7'd64, 48'd3, 32'd1, 16'd0, 1'b0));
    push_event(mk_note(1'b0, 7'd64, 7'd64, TimeTop - 48'd100, LenTop, 16'd0, 1'b1));
    drain();

    // Mordent with full scale at the edges, then notes played as written
    pr    = '0;
    pr[5] = 17'd32768;
    load_profile(12'hFFF, GridStepReset, pr);
    push_event(mk_note(1'b0, 7'd127, 7'd30, 48'd1000, 32'd4000, 16'd0, 1'b1));
    push_event(mk_note(1'b0, 7'd0, 7'd30, 48'd1000, 32'd4000, 16'd0, 1'b0));
    push_event(mk_note(1'b0, 7'd60, 7'd30, 48'd1000, 32'd3, 16'd100, 1'b1));
    push_event(mk_note(1'b0, 7'd0, 7'd0, 48'd0, 32'd1, 16'hFFFF, 1'b0));
    push_event(mk_note(1'b0, 7'd127, 7'd127, TimeTop, LenTop, 16'hFFFF, 1'b1));
    drain();

    // Rest and the running sums past full scale
    pr    = '0;
    pr[0] = 17'd32768;
    pr[1] = 17'd65536;
    pr[2] = 17'd65536;
    load_profile(ScaleMaskReset, GridStepReset, pr);
    push_event(mk_note(1'b0, 7'd40, 7'd40, 48'd20, 32'd80, 16'd0, 1'b1));
    push_event(mk_note(1'b0, 7'd40, 7'd40, 48'd20, 32'd80, 16'd32767, 1'b0));
    push_event(mk_note(1'b0, 7'd40, 7'd40, 48'd20, 32'd80, 16'd32768, 1'b1));
    push_event(mk_note(1'b0, 7'd40, 7'd40, 48'd20, 32'd80, 16'hFFFF, 1'b0));
    drain();

    // Random phases over varied settings
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0)      mask = 12'hFFF;
      else if (ph == 1) mask = 12'd0;
      else              mask = 12'($urandom);
      if (ph == 2)      grid = 22'd655;
      else if (ph == 3) grid = 22'd3932160;
      else if (ph == 4) grid = 22'($urandom_range(655, 3932160));
      else              grid = 22'($urandom_range(655, 65536));
      for (int i = 0; i < NumVar; i++) pr[i] = 17'($urandom_range(0, 14000));
      if (ph == 5) pr[$urandom_range(0, 5)] = 17'd65536;
      if (ph == 6) begin
        pr[0] = '0;
        for (int i = 1; i < NumVar; i++) pr[i] = 17'($urandom_range(0, 65536));
      end
      calm_phase = 1'b0;
      load_profile(mask, grid, pr);
      calm_phase = (ph % 3 == 2);
      repeat (40) push_event(random_event());
      drain();
    end

    calm_phase = 1'b0;
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
